// ----- rtl/nmea_sentence_checksum_check_macros.svh -----
// Assertion macros for the NMEA checksum checker.
// Used by the checker module; depends on nothing else.
`ifndef NMEA_SENTENCE_CHECKSUM_CHECK_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECK_MACROS_SVH

// clocked property, disabled while reset is asserted
`define NSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `NSC_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// antecedent implies consequent in the next cycle
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `NSC_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- rtl/nsc_pkg.sv -----
// Package for the NMEA sentence checksum checker: types, character codes
// and the hex digit decoder. No dependencies.
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] LINE_END_RESET = 8'h0A;
  localparam logic [4:0] HEX_NONE       = 5'd16;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SUM  = 2'd1,
    PH_HEX  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef struct packed {
    logic       sentence_found;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       received_overflow;
  } res_t;

  // digit value 0..15, or HEX_NONE for any other byte
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
    end else begin
      return HEX_NONE;
    end
    return {1'b0, t[3:0]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nsc_stream_if.sv -----
// Valid/ready stream interfaces for the checksum checker: byte input and
// result output. Depends on nothing.
`default_nettype none

interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic       sentence_found;
  logic       checksum_ok;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;
  logic       received_overflow;

  modport source (output valid, output sentence_found, output checksum_ok,
                  output computed_sum, output received_sum,
                  output received_overflow, input ready);
  modport sink   (input valid, input sentence_found, input checksum_ok,
                  input computed_sum, input received_sum,
                  input received_overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/nsc_in_stage.sv -----
// Input register of the checksum checker: holds one accepted byte until
// the line core takes it. Depends on nsc_in_if.
`default_nettype none

module nsc_in_stage (
  input  wire        clk_i,
  input  wire        rst_ni,
  nsc_in_if.sink     in_ch,
  input  wire        take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // a new item may enter when empty or when the held one leaves this cycle
  assign in_ch.ready = !valid_q || take_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_ch.data_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ----- rtl/nsc_line_core.sv -----
// Line state of the checksum checker: phase, running XOR and gathered hex
// value, updated once per byte. Depends on nsc_pkg.
`default_nettype none

module nsc_line_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           step_i,
  input  wire  [7:0]    byte_i,
  input  wire  [7:0]    line_end_i,
  output logic          eol_o,
  output nsc_pkg::res_t res_o
);

  nsc_pkg::phase_e phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] hex_q, hex_d;
  logic       ovf_q, ovf_d;
  logic       star_q, star_d;
  logic [4:0] digit;
  logic       is_hex;

  assign eol_o  = (byte_i == line_end_i);
  assign digit  = nsc_pkg::hex_digit(byte_i);
  assign is_hex = (digit != nsc_pkg::HEX_NONE);

  // next phase; the line end wins over every other byte meaning
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (eol_o) begin
        phase_d = nsc_pkg::PH_HUNT;
      end else begin
        case (phase_q)
          nsc_pkg::PH_HUNT: if (byte_i == nsc_pkg::CHAR_DOLLAR) phase_d = nsc_pkg::PH_SUM;
          nsc_pkg::PH_SUM:  if (byte_i == nsc_pkg::CHAR_STAR) phase_d = nsc_pkg::PH_HEX;
          nsc_pkg::PH_HEX:  if (!is_hex) phase_d = nsc_pkg::PH_DONE;
          default:          phase_d = phase_q;
        endcase
      end
    end
  end

  // data path and result
  always_comb begin
    xor_d  = xor_q;
    hex_d  = hex_q;
    ovf_d  = ovf_q;
    star_d = star_q;
    if (step_i) begin
      if (eol_o) begin
        xor_d  = 8'h00;
        hex_d  = 8'h00;
        ovf_d  = 1'b0;
        star_d = 1'b0;
      end else begin
        case (phase_q)
          nsc_pkg::PH_HUNT: begin
            if (byte_i == nsc_pkg::CHAR_DOLLAR) xor_d = 8'h00;
          end
          nsc_pkg::PH_SUM: begin
            if (byte_i == nsc_pkg::CHAR_STAR) begin
              star_d = 1'b1;
              hex_d  = 8'h00;
            end else begin
              xor_d = xor_q ^ byte_i;
            end
          end
          nsc_pkg::PH_HEX: begin
            if (is_hex) begin
              // a digit shifted past the top nibble marks overflow
              if (|hex_q[7:4]) ovf_d = 1'b1;
              hex_d = {hex_q[3:0], digit[3:0]};
            end
          end
          default: begin
            xor_d = xor_q;
          end
        endcase
      end
    end

    res_o.sentence_found    = (phase_q != nsc_pkg::PH_HUNT);
    res_o.checksum_ok       = star_q && !ovf_q && (xor_q == hex_q);
    res_o.computed_sum      = xor_q;
    res_o.received_sum      = hex_q;
    res_o.received_overflow = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nsc_pkg::PH_HUNT;
      xor_q   <= 8'h00;
      hex_q   <= 8'h00;
      ovf_q   <= 1'b0;
      star_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      hex_q   <= hex_d;
      ovf_q   <= ovf_d;
      star_q  <= star_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nsc_out_stage.sv -----
// Result register of the checksum checker: holds one result until the
// sink takes it. Depends on nsc_pkg and nsc_out_if.
`default_nettype none

module nsc_out_stage (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           load_i,
  input  nsc_pkg::res_t res_i,
  output logic          free_o,
  nsc_out_if.source     out_ch
);

  logic          valid_q, valid_d;
  nsc_pkg::res_t res_q;

  // room for a new result if empty or the held one leaves now
  assign free_o = !valid_q || out_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ch.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_ch.valid             = valid_q;
  assign out_ch.sentence_found    = res_q.sentence_found;
  assign out_ch.checksum_ok       = res_q.checksum_ok;
  assign out_ch.computed_sum      = res_q.computed_sum;
  assign out_ch.received_sum      = res_q.received_sum;
  assign out_ch.received_overflow = res_q.received_overflow;

endmodule

`default_nettype wire

// ----- rtl/nmea_sentence_checksum_check.sv -----
// NMEA sentence checksum checker, top level. Uses nsc_pkg, the stream
// interfaces, nsc_in_stage, nsc_line_core and nsc_out_stage.
// Throughput: one byte per cycle; only a stalled result holding a line-end
// byte in the input register slows intake. A line-end byte goes through the
// input register, its result through the result register. Reset clears the
// line state, both stage valids and sets the line-end byte to 0x0A.
`default_nettype none

module nmea_sentence_checksum_check (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [7:0] cfg_wdata_i,
  nsc_in_if.sink     in_ch_i,
  nsc_out_if.source  out_ch_o
);

  logic [7:0]    line_end_q;
  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          eol;
  logic          out_free;
  logic          take;
  logic          load;
  nsc_pkg::res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_end_q <= nsc_pkg::LINE_END_RESET;
    end else if (cfg_we_i) begin
      line_end_q <= cfg_wdata_i;
    end
  end

  // a line-end byte waits until the result register has room
  assign take = s1_valid && (!eol || out_free);
  assign load = take && eol;

  nsc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch_i),
    .take_i  (take),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  nsc_line_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (take),
    .byte_i     (s1_byte),
    .line_end_i (line_end_q),
    .eol_o      (eol),
    .res_o      (res)
  );

  nsc_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .res_i  (res),
    .free_o (out_free),
    .out_ch (out_ch_o)
  );

endmodule

`default_nettype wire

// ----- rtl/nsc_checker.sv -----
// Port-level assertions for the checksum checker, bound to the top level.
// Depends on nmea_sentence_checksum_check_macros.svh.
`default_nettype none

`include "nmea_sentence_checksum_check_macros.svh"

module nsc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire       sentence_found_i,
  input wire       checksum_ok_i,
  input wire [7:0] computed_sum_i,
  input wire [7:0] received_sum_i,
  input wire       received_overflow_i
);

  `NSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `NSC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(computed_sum_i) && $stable(received_sum_i) && $stable(checksum_ok_i), "stalled result changed")
  `NSC_ASSERT_IMPL(a_ok_needs_sentence, clk_i, rst_ni, out_valid_i && checksum_ok_i, sentence_found_i && !received_overflow_i, "pass without sentence or with overflow")
  `NSC_ASSERT_IMPL(a_ok_sums_match, clk_i, rst_ni, out_valid_i && checksum_ok_i, computed_sum_i == received_sum_i, "pass with unequal sums")
  `NSC_ASSERT_IMPL(a_no_sentence_zero, clk_i, rst_ni, out_valid_i && !sentence_found_i, computed_sum_i == 8'h00 && received_sum_i == 8'h00 && !received_overflow_i, "nonzero sums on line without sentence")

endmodule

bind nmea_sentence_checksum_check nsc_checker u_nsc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_ch_o.valid),
  .out_ready_i         (out_ch_o.ready),
  .sentence_found_i    (out_ch_o.sentence_found),
  .checksum_ok_i       (out_ch_o.checksum_ok),
  .computed_sum_i      (out_ch_o.computed_sum),
  .received_sum_i      (out_ch_o.received_sum),
  .received_overflow_i (out_ch_o.received_overflow)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for nmea_sentence_checksum_check: drives byte streams of NMEA
// sentences and noise, and checks every end-of-line result against its own
// line predictor. Uses nsc_pkg and the nsc_in_if / nsc_out_if interfaces.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          MAX_REPORTS  = 10;

  // Tracks the line state of the checker and holds the results it owes.
  class sentence_scoreboard;
    logic [7:0]      line_end;
    nsc_pkg::phase_e phase;
    logic [7:0]      run_xor;
    logic [7:0]      hex_val;
    logic            hex_ovf;
    logic            star_seen;
    nsc_pkg::res_t   owed_q[$];
    int              errors;

    function new();
      line_end = nsc_pkg::LINE_END_RESET;
      errors   = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase     = nsc_pkg::PH_HUNT;
      run_xor   = '0;
      hex_val   = '0;
      hex_ovf   = 1'b0;
      star_seen = 1'b0;
    endfunction

    function logic [4:0] digit_of(logic [7:0] c);
      logic [4:0] d;
      d = nsc_pkg::HEX_NONE;
      if (c >= "0" && c <= "9") begin
        d = 5'(c - "0");
      end else if (c >= "a" && c <= "f") begin
        d = 5'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
        d = 5'(c - "A" + 8'd10);
      end
      return d;
    endfunction

    function string show(nsc_pkg::res_t r);
      return $sformatf("found=%0b ok=%0b computed=%02h received=%02h ovf=%0b",
                       r.sentence_found, r.checksum_ok, r.computed_sum,
                       r.received_sum, r.received_overflow);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [4:0]    d;
      nsc_pkg::res_t r;
      d = digit_of(b);
      // the line end wins over every other meaning of the byte
      if (b == line_end) begin
        r.sentence_found    = (phase != nsc_pkg::PH_HUNT);
        r.checksum_ok       = star_seen && !hex_ovf && (run_xor == hex_val);
        r.computed_sum      = run_xor;
        r.received_sum      = hex_val;
        r.received_overflow = hex_ovf;
        owed_q.push_back(r);
        clear_line();
      end else begin
        case (phase)
          nsc_pkg::PH_HUNT: begin
            if (b == nsc_pkg::CHAR_DOLLAR) begin
              phase   = nsc_pkg::PH_SUM;
              run_xor = '0;
            end
          end
          nsc_pkg::PH_SUM: begin
            if (b == nsc_pkg::CHAR_STAR) begin
              star_seen = 1'b1;
              phase     = nsc_pkg::PH_HEX;
              hex_val   = '0;
            end else begin
              run_xor = run_xor ^ b;
            end
          end
          nsc_pkg::PH_HEX: begin
            if (d != nsc_pkg::HEX_NONE) begin
              if (hex_val > 8'd15) hex_ovf = 1'b1;
              hex_val = {hex_val[3:0], d[3:0]};
            end else begin
              phase = nsc_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
    endfunction

    function void check_result(nsc_pkg::res_t got);
      nsc_pkg::res_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result: %s", show(got));
        return;
      end
      want = owed_q.pop_front();
      if (got.sentence_found !== want.sentence_found ||
          got.checksum_ok !== want.checksum_ok ||
          got.computed_sum !== want.computed_sum ||
          got.received_sum !== want.received_sum ||
          got.received_overflow !== want.received_overflow) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction

    function void check_drained();
      if (owed_q.size() != 0) begin
        errors += owed_q.size();
        $display("%0d results never arrived", owed_q.size());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int          items_sent = 0;
  sentence_scoreboard sb;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();

  nmea_sentence_checksum_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch_i     (in_ch),
    .out_ch_o    (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    nsc_pkg::res_t got;
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.sentence_found    = out_ch.sentence_found;
      got.checksum_ok       = out_ch.checksum_ok;
      got.computed_sum      = out_ch.computed_sum;
      got.received_sum      = out_ch.received_sum;
      got.received_overflow = out_ch.received_overflow;
      sb.check_result(got);
    end
  end

  // result side: stall in bursts, hold ready high once calm
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      out_ch.ready <= 1'b1;
      if (calm) begin
        @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(40, 80)) @(posedge clk_i);
        else repeat ($urandom_range(1, 20)) @(posedge clk_i);
        if (!calm) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk_i);
        end
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return "0" + 8'(v);
    return (upper ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit gaps);
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
  endtask

  // hold off input until every owed result is in, then let the stages empty
  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_line_end(input logic [7:0] v);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.line_end = v;
  endtask

  task automatic send_line(input bit gaps);
    logic [7:0] q[$];
    logic [7:0] sum;
    logic [7:0] c;
    int         mode;
    sum = '0;
    repeat ($urandom_range(0, 2)) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c != nsc_pkg::CHAR_DOLLAR && c != sb.line_end) q.push_back(c);
    end
    q.push_back(nsc_pkg::CHAR_DOLLAR);
    repeat ($urandom_range(0, 10)) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c != nsc_pkg::CHAR_STAR && c != sb.line_end) begin
        q.push_back(c);
        sum = sum ^ c;
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      q.push_back(nsc_pkg::CHAR_STAR);
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        q.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
        q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
      end else if (mode == 6) begin
        q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end else if (mode == 7) begin
        repeat ($urandom_range(3, 4))
          q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end else if (mode == 8) begin
        repeat (2)
          q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      // trailing junk after the digits
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c != sb.line_end) q.push_back(c);
        end
      end
    end
    q.push_back(sb.line_end);
    foreach (q[i]) send_byte(q[i], gaps);
  endtask

  task automatic run_random(input int count);
    int start;
    bit gaps;
    start = items_sent;
    while (items_sent - start < count) begin
      gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), gaps);
      end else begin
        send_line(gaps);
      end
    end
  endtask

  initial begin
    sb = new();
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_ni          <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_str("\n");
    send_str("$A*41\n");
    send_str("$*\n");
    send_str("x$B\n");
    send_str("$*1ff\n");
    send_str("$$*x2\n");

    run_random(250);
    go_idle();
    run_random(50);
    write_line_end(8'h0D);
    run_random(180);
    write_line_end(8'h00);
    run_random(130);
    write_line_end(8'hFF);
    run_random(100);
    // star as line end: it must close the line instead of starting the digits
    write_line_end(nsc_pkg::CHAR_STAR);
    run_random(80);
    write_line_end(nsc_pkg::LINE_END_RESET);
    calm = 1'b1;
    run_random(150);

    go_idle();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
